// File: hw/rtl/sprite_sort_and_batch_macros.svh
// ----------------------------------------------------------------------------
// sprite sort and batch assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SPRITE_SORT_AND_BATCH_MACROS_SVH
`define SPRITE_SORT_AND_BATCH_MACROS_SVH

// expression holds on every clock edge out of reset
`define SBS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("sbs assertion failed");

// antecedent implies consequent in the same cycle
`define SBS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbs assertion failed");

// antecedent implies consequent in the next cycle
`define SBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbs assertion failed");

`endif

// File: hw/rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// shared constants, types and command/status structs of the sprite sorter
// ----------------------------------------------------------------------------
package sbs_pkg;

    // sizing
    localparam int MAX_SPRITES = 64;
    localparam int IDX_W       = $clog2(MAX_SPRITES);
    localparam int CNT_W       = $clog2(MAX_SPRITES + 1);
    localparam int TEX_W       = 16;
    localparam int DEP_W       = 32;
    localparam int REC_W       = TEX_W + DEP_W;
    localparam int VTX_W       = 9;
    localparam int SIDX_W      = 6;
    localparam int VERTS       = 6;
    localparam int MODE_W      = 2;
    localparam int PADDR_W     = 2;

    // register index
    localparam int REG_SORT_MODE = 0;

    // sort modes
    localparam logic [MODE_W-1:0] MODE_NONE       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXTURE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RI_RD,
        ST_RI_LAT,
        ST_RJ_RD,
        ST_RJ_CMP,
        ST_RI_WR,
        ST_E_ORD,
        ST_E_REC,
        ST_E_DAT,
        ST_S_ORD,
        ST_S_REC,
        ST_S_DAT,
        ST_E_OUT,
        ST_E_WAIT
    } t_state;

    // store read address source
    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_ORD
    } t_rd_sel;

    // order table read address source
    typedef enum logic {
        ORD_K,
        ORD_P
    } t_ord_sel;

    typedef struct packed {
        logic     load;
        logic     i_clr;
        logic     latch_i;
        logic     j_clr;
        logic     cmp_acc;
        logic     order_wr;
        logic     k_clr;
        logic     latch_rec;
        logic     latch_tex;
        logic     run_start;
        logic     p_inc;
        logic     run_end;
        logic     out_load;
        logic     k_inc;
        logic     batch_clr;
        t_rd_sel  rd_sel;
        t_ord_sel ord_sel;
    } t_cmd;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic k_last;
        logic p_end;
        logic starts;
        logic tex_match;
        logic out_ack;
    } t_stat;

endpackage

// File: hw/rtl/sbs_ram.sv
// ----------------------------------------------------------------------------
// sbs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sbs_datapath.sv
// ----------------------------------------------------------------------------
// sbs_datapath
// sprite store, order table, rank counters, run tracking and output register
// ----------------------------------------------------------------------------
module sbs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbs_pkg::t_cmd                 i_cmd,
    output sbs_pkg::t_stat                o_stat,
    input  logic [sbs_pkg::MODE_W-1:0]    i_sort_mode,
    input  logic [sbs_pkg::TEX_W-1:0]     i_texture_id,
    input  logic signed [sbs_pkg::DEP_W-1:0] i_depth_key,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [sbs_pkg::SIDX_W-1:0]    o_sprite_index,
    output logic [sbs_pkg::TEX_W-1:0]     o_texture_out,
    output logic                          o_run_start,
    output logic [sbs_pkg::VTX_W-1:0]     o_run_vertex_offset,
    output logic [sbs_pkg::VTX_W-1:0]     o_run_vertex_count,
    output logic                          o_overflowed,
    output logic                          o_last_out
);
    import sbs_pkg::*;

    logic [CNT_W-1:0] r_count, r_i, r_j, r_rank, r_k, r_p, r_run_first, r_run_end;
    logic             r_drop;
    logic [TEX_W-1:0] r_ti, r_tex;
    logic signed [DEP_W-1:0] r_di;
    logic [IDX_W-1:0] r_rec;
    logic             r_starts;
    logic             r_valid;
    logic [SIDX_W-1:0] r_o_idx;
    logic [TEX_W-1:0] r_o_tex;
    logic             r_o_start, r_o_drop, r_o_last;
    logic [VTX_W-1:0] r_o_off, r_o_cnt;

    logic             store_we;
    logic [IDX_W-1:0] store_raddr, ord_raddr;
    logic [REC_W-1:0] store_rdata;
    logic [IDX_W-1:0] ord_rdata;
    logic [TEX_W-1:0] rd_tex;
    logic signed [DEP_W-1:0] rd_dep;
    logic             j_before_i, i_before_j, counts;
    logic [CNT_W-1:0] last_pos;

    assign store_we = i_cmd.load && (r_count < CNT_W'(MAX_SPRITES));
    assign rd_tex   = store_rdata[REC_W-1:DEP_W];
    assign rd_dep   = store_rdata[DEP_W-1:0];
    assign last_pos = r_count - CNT_W'(1);

    // store read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_I:    store_raddr = r_i[IDX_W-1:0];
            RD_J:    store_raddr = r_j[IDX_W-1:0];
            RD_ORD:  store_raddr = ord_rdata;
            default: store_raddr = ord_rdata;
        endcase
        ord_raddr = (i_cmd.ord_sel == ORD_P) ? r_p[IDX_W-1:0] : r_k[IDX_W-1:0];
    end

    sbs_ram #(.WIDTH(REC_W), .DEPTH(MAX_SPRITES)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_texture_id, i_depth_key}),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    sbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SPRITES)) u_order (
        .i_clk   (i_clk),
        .i_we    (i_cmd.order_wr),
        .i_waddr (r_rank[IDX_W-1:0]),
        .i_wdata (r_i[IDX_W-1:0]),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // ordering of record j against the held record i
    always_comb begin
        case (i_sort_mode)
            MODE_DEPTH_ASC: begin
                j_before_i = rd_dep < r_di;
                i_before_j = r_di < rd_dep;
            end
            MODE_DEPTH_DESC: begin
                j_before_i = rd_dep > r_di;
                i_before_j = r_di > rd_dep;
            end
            default: begin
                j_before_i = rd_tex < r_ti;
                i_before_j = r_ti < rd_tex;
            end
        endcase
        // ties keep load order
        counts = j_before_i || (!i_before_j && (r_j < r_i));
    end

    // status back to the controller
    assign o_stat.i_last    = (r_i == last_pos);
    assign o_stat.j_last    = (r_j == last_pos);
    assign o_stat.k_last    = (r_k == last_pos);
    assign o_stat.p_end     = (r_p == r_count);
    assign o_stat.starts    = (r_k == '0) || (rd_tex != r_tex);
    assign o_stat.tex_match = (rd_tex == r_tex);
    assign o_stat.out_ack   = r_valid && i_ready;

    // control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (store_we) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.batch_clr) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // rank pass and emit pass working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.order_wr) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (i_cmd.latch_i) begin
            r_ti <= rd_tex;
            r_di <= rd_dep;
        end
        if (i_cmd.j_clr) begin
            r_j    <= '0;
            r_rank <= '0;
        end else if (i_cmd.cmp_acc) begin
            r_j <= r_j + CNT_W'(1);
            if (counts) begin
                r_rank <= r_rank + CNT_W'(1);
            end
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.latch_rec) begin
            r_rec <= ord_rdata;
        end
        if (i_cmd.latch_tex) begin
            r_tex    <= rd_tex;
            r_starts <= o_stat.starts;
        end
        if (i_cmd.run_start) begin
            r_run_first <= r_k;
            r_p         <= r_k + CNT_W'(1);
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + CNT_W'(1);
        end
        if (i_cmd.run_end) begin
            r_run_end <= r_p;
        end
        // output register
        if (i_cmd.out_load) begin
            r_o_idx   <= SIDX_W'(r_rec);
            r_o_tex   <= r_tex;
            r_o_start <= r_starts;
            r_o_off   <= VTX_W'(r_run_first * VERTS);
            r_o_cnt   <= VTX_W'((r_run_end - r_run_first) * VERTS);
            r_o_drop  <= r_drop;
            r_o_last  <= (r_k == last_pos);
        end
    end

    assign o_valid             = r_valid;
    assign o_sprite_index      = r_o_idx;
    assign o_texture_out       = r_o_tex;
    assign o_run_start         = r_o_start;
    assign o_run_vertex_offset = r_o_off;
    assign o_run_vertex_count  = r_o_cnt;
    assign o_overflowed        = r_o_drop;
    assign o_last_out          = r_o_last;

endmodule

// File: hw/rtl/sbs_ctrl.sv
// ----------------------------------------------------------------------------
// sbs_ctrl
// sequencer for load, rank pass, run scan and ordered emit
// ----------------------------------------------------------------------------
module sbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_sprite,
    output logic           o_ready,
    input  sbs_pkg::t_stat i_stat,
    output sbs_pkg::t_cmd  o_cmd
);
    import sbs_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_ORD;
        o_cmd.ord_sel = ORD_K;
        o_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_sprite) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = ST_RI_RD;
                    end
                end
            end
            // rank of record i: count records that sort ahead of it
            ST_RI_RD: begin
                o_cmd.rd_sel = RD_I;
                n_state      = ST_RI_LAT;
            end
            ST_RI_LAT: begin
                o_cmd.latch_i = 1'b1;
                o_cmd.j_clr   = 1'b1;
                n_state       = ST_RJ_RD;
            end
            ST_RJ_RD: begin
                o_cmd.rd_sel = RD_J;
                n_state      = ST_RJ_CMP;
            end
            ST_RJ_CMP: begin
                o_cmd.cmp_acc = 1'b1;
                n_state       = i_stat.j_last ? ST_RI_WR : ST_RJ_RD;
            end
            ST_RI_WR: begin
                o_cmd.order_wr = 1'b1;
                if (i_stat.i_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = ST_E_ORD;
                end else begin
                    n_state = ST_RI_RD;
                end
            end
            // fetch record at sorted position k
            ST_E_ORD: begin
                o_cmd.ord_sel = ORD_K;
                n_state       = ST_E_REC;
            end
            ST_E_REC: begin
                o_cmd.rd_sel    = RD_ORD;
                o_cmd.latch_rec = 1'b1;
                n_state         = ST_E_DAT;
            end
            ST_E_DAT: begin
                o_cmd.latch_tex = 1'b1;
                if (i_stat.starts) begin
                    o_cmd.run_start = 1'b1;
                    n_state         = ST_S_ORD;
                end else begin
                    n_state = ST_E_OUT;
                end
            end
            // scan ahead for the end of the run
            ST_S_ORD: begin
                o_cmd.ord_sel = ORD_P;
                if (i_stat.p_end) begin
                    o_cmd.run_end = 1'b1;
                    n_state       = ST_E_OUT;
                end else begin
                    n_state = ST_S_REC;
                end
            end
            ST_S_REC: begin
                o_cmd.rd_sel = RD_ORD;
                n_state      = ST_S_DAT;
            end
            ST_S_DAT: begin
                if (i_stat.tex_match) begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = ST_S_ORD;
                end else begin
                    o_cmd.run_end = 1'b1;
                    n_state       = ST_E_OUT;
                end
            end
            ST_E_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (i_stat.out_ack) begin
                    o_cmd.k_inc = 1'b1;
                    if (i_stat.k_last) begin
                        o_cmd.batch_clr = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        n_state = ST_E_ORD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sprite_sort_and_batch.sv
// ----------------------------------------------------------------------------
// sprite_sort_and_batch
// loads sprite records, stable-sorts them and emits them with texture runs
// ----------------------------------------------------------------------------
// Sprites load one per cycle into a 64-entry store; the sprite marked last
// starts the sort, and no input transaction is taken until the whole batch
// has been emitted. The sort ranks each record by reading every stored
// record once through the store's single read port and counting the records
// that sort ahead of it. Emit then fetches the sprites in sorted order; at
// the first sprite of a texture run it scans the following records until
// the texture changes or the batch ends, and each output waits for ready.
// Records beyond 64 are dropped and the batch is flagged as overflowed.
// sort_mode is written over the APB port at address 0; the user must write
// it only while the block idles, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sprite_sort_and_batch (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbs_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sbs_pkg::TEX_W-1:0]          i_texture_id,
    input  logic signed [sbs_pkg::DEP_W-1:0]   i_depth_key,
    input  logic                               i_last_sprite,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sbs_pkg::SIDX_W-1:0]         o_sprite_index,
    output logic [sbs_pkg::TEX_W-1:0]          o_texture_out,
    output logic                               o_run_start,
    output logic [sbs_pkg::VTX_W-1:0]          o_run_vertex_offset,
    output logic [sbs_pkg::VTX_W-1:0]          o_run_vertex_count,
    output logic                               o_overflowed,
    output logic                               o_last_out
);
    import sbs_pkg::*;

    logic [MODE_W-1:0] r_sort_mode;
    t_cmd              cmd;
    t_stat             stat;

    // sort mode register write at its address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_mode <= MODE_NONE;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == PADDR_W'(4*REG_SORT_MODE))) begin
            r_sort_mode <= pwdata[MODE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(32 - MODE_W){1'b0}}, r_sort_mode};

    sbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_sprite (i_last_sprite),
        .o_ready       (o_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    sbs_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_sort_mode         (r_sort_mode),
        .i_texture_id        (i_texture_id),
        .i_depth_key         (i_depth_key),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_sprite_index      (o_sprite_index),
        .o_texture_out       (o_texture_out),
        .o_run_start         (o_run_start),
        .o_run_vertex_offset (o_run_vertex_offset),
        .o_run_vertex_count  (o_run_vertex_count),
        .o_overflowed        (o_overflowed),
        .o_last_out          (o_last_out)
    );

endmodule

// File: hw/rtl/sbs_checker.sv
// ----------------------------------------------------------------------------
// sbs_assertions
// port-level checks on the sprite sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "sprite_sort_and_batch_macros.svh"

module sbs_assertions (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             i_last_sprite,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [sbs_pkg::SIDX_W-1:0]       o_sprite_index,
    input logic [sbs_pkg::VTX_W-1:0]        o_run_vertex_count
);

    // a stalled result transaction holds
    `SBS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_sprite_index))
    // loading and emitting never overlap
    `SBS_ASSERT_ALWAYS(a_no_overlap, !(o_ready && o_valid))
    // the last sprite closes the input side
    `SBS_ASSERT_NEXT(a_last_closes, i_valid && o_ready && i_last_sprite, !o_ready)
    // every run holds at least one sprite
    `SBS_ASSERT_SAME(a_run_nonzero, o_valid, o_run_vertex_count != '0)

endmodule

bind sprite_sort_and_batch sbs_assertions u_sbs_assertions (.*);
